/* rtl/trc_pkg.sv */
// Shared types, constants and the multiply-accumulate program of the readability counter.
`timescale 1ns / 1ps

package trc_pkg;

    // Widths of the shared arithmetic unit and of the result fields.
    localparam int MUL_W   = 32;
    localparam int ACC_W   = 96;
    localparam int INDEX_W = 16;
    localparam int QUO_W   = INDEX_W + 1;
    localparam int FIELD_W = 24;
    localparam int MAC_OPS = 11;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
    localparam logic [INDEX_W-1:0] INDEX_MIN = {1'b1, {(INDEX_W-1){1'b0}}};
    localparam logic [INDEX_W-1:0] INDEX_MAX = {1'b0, {(INDEX_W-1){1'b1}}};

    // Flesch coefficients scaled by 1000: D = 1000*W*T,
    // N = 206835*W*T - 84600*S*T - 1015*W*W.
    localparam logic [MUL_W-1:0] K_DEN  = 32'd1000;
    localparam logic [MUL_W-1:0] K_BASE = 32'd206835;
    localparam logic [MUL_W-1:0] K_SYL  = 32'd84600;
    localparam logic [MUL_W-1:0] K_WRD  = 32'd1015;

    typedef enum logic [2:0] {
        OPA_W,
        OPA_S,
        OPA_WT_LO,
        OPA_WT_HI,
        OPA_ST_LO,
        OPA_ST_HI,
        OPA_WW_LO,
        OPA_WW_HI
    } opa_sel_t;

    typedef enum logic [2:0] {
        OPB_T,
        OPB_W,
        OPB_K_DEN,
        OPB_K_BASE,
        OPB_K_SYL,
        OPB_K_WRD
    } opb_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_WT,
        ACT_ST,
        ACT_WW,
        ACT_LOAD,
        ACT_LOAD_D,
        ACT_ADD_HI,
        ACT_SUB_LO,
        ACT_SUB_HI
    } mac_act_t;

    typedef struct packed {
        opa_sel_t a_sel;
        opb_sel_t b_sel;
        mac_act_t act;
    } mac_op_t;

    typedef struct packed {
        logic               done;
        logic [INDEX_W-1:0] index;
    } calc_res_t;

    // One multiply per step; the action is applied to the registered product in the next step.
    function automatic mac_op_t mac_op(input logic [3:0] step);
        mac_op_t op;
        op = '{a_sel: OPA_W, b_sel: OPB_T, act: ACT_NONE};
        case (step)
            4'd0:    op = '{a_sel: OPA_W,     b_sel: OPB_T,      act: ACT_WT};
            4'd1:    op = '{a_sel: OPA_S,     b_sel: OPB_T,      act: ACT_ST};
            4'd2:    op = '{a_sel: OPA_W,     b_sel: OPB_W,      act: ACT_WW};
            4'd3:    op = '{a_sel: OPA_WT_LO, b_sel: OPB_K_DEN,  act: ACT_LOAD};
            4'd4:    op = '{a_sel: OPA_WT_HI, b_sel: OPB_K_DEN,  act: ACT_ADD_HI};
            4'd5:    op = '{a_sel: OPA_WT_LO, b_sel: OPB_K_BASE, act: ACT_LOAD_D};
            4'd6:    op = '{a_sel: OPA_WT_HI, b_sel: OPB_K_BASE, act: ACT_ADD_HI};
            4'd7:    op = '{a_sel: OPA_ST_LO, b_sel: OPB_K_SYL,  act: ACT_SUB_LO};
            4'd8:    op = '{a_sel: OPA_ST_HI, b_sel: OPB_K_SYL,  act: ACT_SUB_HI};
            4'd9:    op = '{a_sel: OPA_WW_LO, b_sel: OPB_K_WRD,  act: ACT_SUB_LO};
            4'd10:   op = '{a_sel: OPA_WW_HI, b_sel: OPB_K_WRD,  act: ACT_SUB_HI};
            default: op = '{a_sel: OPA_W,     b_sel: OPB_T,      act: ACT_NONE};
        endcase
        return op;
    endfunction

endpackage

/* rtl/trc_calc.sv */
// Index unit: one shared multiplier and one shared wide adder under a small sequencer.
`timescale 1ns / 1ps

module trc_calc #(
    parameter int COUNT_BITS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [COUNT_BITS-1:0]   syl,
    input  logic [COUNT_BITS-1:0]   words,
    input  logic [COUNT_BITS-1:0]   sents,
    output trc_pkg::calc_res_t      res
);

    localparam int ACC_W = trc_pkg::ACC_W;
    localparam int MUL_W = trc_pkg::MUL_W;
    localparam int QUO_W = trc_pkg::QUO_W;
    localparam int IDX_W = trc_pkg::INDEX_W;
    localparam int CNT_W = $clog2(QUO_W);

    typedef enum logic [6:0] {
        C_IDLE = 7'b0000001,
        C_MAC  = 7'b0000010,
        C_ABS  = 7'b0000100,
        C_SUMX = 7'b0001000,
        C_OVF  = 7'b0010000,
        C_DIV  = 7'b0100000,
        C_DONE = 7'b1000000
    } cstate_t;

    cstate_t                state_reg, state_next;
    logic [3:0]             step_reg, step_next;
    trc_pkg::mac_act_t      act_reg, act_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [2*MUL_W-1:0]     prod_reg, prod_next;
    logic [2*MUL_W-1:0]     wt_reg, wt_next;
    logic [2*MUL_W-1:0]     st_reg, st_next;
    logic [2*MUL_W-1:0]     ww_reg, ww_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [ACC_W-1:0]       d_reg, d_next;
    logic [ACC_W-1:0]       ydiv_reg, ydiv_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic                   neg_reg, neg_next;
    logic                   ovf_reg, ovf_next;

    trc_pkg::mac_op_t       op;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [2*MUL_W-1:0]     mul_res;
    logic [ACC_W-1:0]       prod_ext;
    logic [ACC_W-1:0]       prod_hi;
    logic [ACC_W-1:0]       add_a;
    logic [ACC_W-1:0]       add_b;
    logic                   add_cin;
    logic [ACC_W:0]         add_sum;
    logic                   ge;
    logic [QUO_W-1:0]       quo_neg;
    logic                   big_neg;
    logic                   big_pos;

    assign op = trc_pkg::mac_op(step_reg);

    // Shared 32x32 multiplier.
    always_comb begin
        case (op.a_sel)
            trc_pkg::OPA_W:     mul_a = MUL_W'(words);
            trc_pkg::OPA_S:     mul_a = MUL_W'(syl);
            trc_pkg::OPA_WT_LO: mul_a = wt_reg[MUL_W-1:0];
            trc_pkg::OPA_WT_HI: mul_a = wt_reg[2*MUL_W-1:MUL_W];
            trc_pkg::OPA_ST_LO: mul_a = st_reg[MUL_W-1:0];
            trc_pkg::OPA_ST_HI: mul_a = st_reg[2*MUL_W-1:MUL_W];
            trc_pkg::OPA_WW_LO: mul_a = ww_reg[MUL_W-1:0];
            trc_pkg::OPA_WW_HI: mul_a = ww_reg[2*MUL_W-1:MUL_W];
            default:            mul_a = '0;
        endcase
        case (op.b_sel)
            trc_pkg::OPB_T:      mul_b = MUL_W'(sents);
            trc_pkg::OPB_W:      mul_b = MUL_W'(words);
            trc_pkg::OPB_K_DEN:  mul_b = trc_pkg::K_DEN;
            trc_pkg::OPB_K_BASE: mul_b = trc_pkg::K_BASE;
            trc_pkg::OPB_K_SYL:  mul_b = trc_pkg::K_SYL;
            trc_pkg::OPB_K_WRD:  mul_b = trc_pkg::K_WRD;
            default:             mul_b = '0;
        endcase
    end

    assign mul_res  = mul_a * mul_b;
    assign prod_ext = ACC_W'(prod_reg);
    assign prod_hi  = prod_ext << MUL_W;

    // Shared wide adder. By default it runs the trial subtraction of the divider.
    always_comb begin
        add_a   = acc_reg;
        add_b   = ~ydiv_reg;
        add_cin = 1'b1;
        case (state_reg)
            C_MAC: begin
                case (act_reg)
                    trc_pkg::ACT_LOAD, trc_pkg::ACT_LOAD_D: begin
                        add_a   = '0;
                        add_b   = prod_ext;
                        add_cin = 1'b0;
                    end
                    trc_pkg::ACT_ADD_HI: begin
                        add_b   = prod_hi;
                        add_cin = 1'b0;
                    end
                    trc_pkg::ACT_SUB_LO: begin
                        add_b   = ~prod_ext;
                    end
                    trc_pkg::ACT_SUB_HI: begin
                        add_b   = ~prod_hi;
                    end
                    default: begin
                        add_b   = ~ydiv_reg;
                    end
                endcase
            end
            C_ABS: begin
                add_a   = '0;
                add_b   = ~acc_reg;
            end
            C_SUMX: begin
                add_a   = acc_reg << 1;
                add_b   = d_reg;
                add_cin = 1'b0;
            end
            default: begin
                add_a   = acc_reg;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (ACC_W+1)'(add_cin);
    assign ge      = add_sum[ACC_W];

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        act_next   = act_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        wt_next    = wt_reg;
        st_next    = st_reg;
        ww_next    = ww_reg;
        acc_next   = acc_reg;
        d_next     = d_reg;
        ydiv_next  = ydiv_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            C_IDLE: begin
                if (start) begin
                    step_next  = '0;
                    act_next   = trc_pkg::ACT_NONE;
                    state_next = C_MAC;
                end
            end
            C_MAC: begin
                prod_next = mul_res;
                act_next  = op.act;
                step_next = step_reg + 4'd1;
                case (act_reg)
                    trc_pkg::ACT_WT:     wt_next = prod_reg;
                    trc_pkg::ACT_ST:     st_next = prod_reg;
                    trc_pkg::ACT_WW:     ww_next = prod_reg;
                    trc_pkg::ACT_LOAD_D: begin
                        d_next   = acc_reg;
                        acc_next = add_sum[ACC_W-1:0];
                    end
                    trc_pkg::ACT_LOAD, trc_pkg::ACT_ADD_HI,
                    trc_pkg::ACT_SUB_LO, trc_pkg::ACT_SUB_HI: begin
                        acc_next = add_sum[ACC_W-1:0];
                    end
                    default: begin
                        acc_next = acc_reg;
                    end
                endcase
                if (step_reg == 4'(trc_pkg::MAC_OPS)) begin
                    state_next = C_ABS;
                end
            end
            C_ABS: begin
                neg_next = acc_reg[ACC_W-1];
                if (acc_reg[ACC_W-1]) begin
                    acc_next = add_sum[ACC_W-1:0];
                end
                state_next = C_SUMX;
            end
            C_SUMX: begin
                // Dividend 2|N| + D over divisor 2D rounds half away from zero.
                acc_next   = add_sum[ACC_W-1:0];
                ydiv_next  = d_reg << (QUO_W + 1);
                state_next = C_OVF;
            end
            C_OVF: begin
                ovf_next   = ge;
                ydiv_next  = ydiv_reg >> 1;
                quo_next   = '0;
                cnt_next   = CNT_W'(QUO_W - 1);
                state_next = C_DIV;
            end
            C_DIV: begin
                if (ge) begin
                    acc_next = add_sum[ACC_W-1:0];
                end
                quo_next  = {quo_reg[QUO_W-2:0], ge};
                ydiv_next = ydiv_reg >> 1;
                if (cnt_reg == '0) begin
                    state_next = C_DONE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            C_DONE: begin
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            act_reg   <= trc_pkg::ACT_NONE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            act_reg   <= act_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        prod_reg <= prod_next;
        wt_reg   <= wt_next;
        st_reg   <= st_next;
        ww_reg   <= ww_next;
        acc_reg  <= acc_next;
        d_reg    <= d_next;
        ydiv_reg <= ydiv_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
    end

    // Apply the sign and saturate the rounded magnitude.
    assign quo_neg = ~quo_reg + QUO_W'(1);
    assign big_neg = ovf_reg || (quo_reg > QUO_W'(2 ** (IDX_W - 1)));
    assign big_pos = ovf_reg || (quo_reg > QUO_W'(2 ** (IDX_W - 1) - 1));

    always_comb begin
        res.done = (state_reg == C_DONE);
        if (neg_reg) begin
            res.index = big_neg ? trc_pkg::INDEX_MIN : quo_neg[IDX_W-1:0];
        end else begin
            res.index = big_pos ? trc_pkg::INDEX_MAX : quo_reg[IDX_W-1:0];
        end
    end

endmodule

/* rtl/text_readability_counter.sv */
// Top level of the streaming text readability counter (Flesch reading ease).
// Usage:
// The input channel (in_valid / in_ready) takes one text byte per word, with
// end_of_text marking the last byte of a text. Ordinary bytes are taken at one
// per cycle; the scanner keeps one byte of look-behind to decide vowel and
// sentence-mark runs. After the final byte the block drops in_ready and works
// out the index with the multiply program on the single 32x32 multiplier and
// then the 17 restoring divide steps on the shared 96-bit adder. A text whose
// word or sentence count is zero skips the index unit: T_CHECK passes it
// straight to T_LOAD, where its result is loaded for the receiver.
// One result word (three saturating counts, the rounded index and an error
// flag) is held in an output register on out_valid / out_ready. While that word
// waits, the next text already streams in; only a second finished result waits
// for the receiver. Reset clears all counts and leaves the block ready, with
// no result pending. After each result the counts return to zero.
`timescale 1ns / 1ps

module text_readability_counter #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          text_byte,
    input  logic                                end_of_text,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [trc_pkg::FIELD_W-1:0]         syllable_total,
    output logic [trc_pkg::FIELD_W-1:0]         word_total,
    output logic [trc_pkg::FIELD_W-1:0]         sentence_total,
    output logic signed [trc_pkg::INDEX_W-1:0]  reading_index,
    output logic                                index_error
);

    localparam int FW = trc_pkg::FIELD_W;
    localparam int IW = trc_pkg::INDEX_W;

    typedef enum logic [3:0] {
        T_RUN   = 4'b0001,
        T_CHECK = 4'b0010,
        T_CALC  = 4'b0100,
        T_LOAD  = 4'b1000
    } tstate_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_E     = 8'h65;

    tstate_t                state_reg, state_next;
    logic [7:0]             prev_byte_reg, prev_byte_next;
    logic                   prev_valid_reg, prev_valid_next;
    logic                   inside_reg, inside_next;
    logic [7:0]             ws_reg, ws_next;
    logic [COUNT_BITS-1:0]  syl_reg, syl_next;
    logic [COUNT_BITS-1:0]  word_reg, word_next;
    logic [COUNT_BITS-1:0]  sent_reg, sent_next;
    logic                   err_reg, err_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FW-1:0]          syl_out_reg, syl_out_next;
    logic [FW-1:0]          word_out_reg, word_out_next;
    logic [FW-1:0]          sent_out_reg, sent_out_next;
    logic [IW-1:0]          index_out_reg, index_out_next;
    logic                   err_out_reg, err_out_next;

    // Scanner results for the byte on the input.
    logic [7:0]             ws_mid;
    logic                   inside_mid;
    logic [COUNT_BITS-1:0]  syl_mid;
    logic [COUNT_BITS-1:0]  word_mid;
    logic [COUNT_BITS-1:0]  sent_mid;
    logic [7:0]             ws_fin;
    logic [COUNT_BITS-1:0]  syl_fin;
    logic [COUNT_BITS-1:0]  sent_fin;
    logic                   prev_counts;

    logic                   accept;
    logic                   check_err;
    logic                   calc_start;
    trc_pkg::calc_res_t     calc_res;

    function automatic logic is_vowel(input logic [7:0] b);
        case (b)
            "a", "e", "i", "o", "u", "y",
            "A", "E", "I", "O", "U", "Y": return 1'b1;
            default:                      return 1'b0;
        endcase
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_NL);
    endfunction

    function automatic logic is_mark(input logic [7:0] b);
        case (b)
            ".", "?", "!", ":", ";": return 1'b1;
            default:                 return 1'b0;
        endcase
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                       input logic [7:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + (COUNT_BITS+1)'(b);
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [7:0] sat_inc8(input logic [7:0] a);
        return (a == 8'hFF) ? a : a + 8'd1;
    endfunction

    function automatic logic [7:0] word_weight(input logic [7:0] a);
        return (a == 8'd0) ? 8'd1 : a;
    endfunction

    function automatic logic [FW-1:0] clamp_field(input logic [COUNT_BITS-1:0] v);
        logic [31:0] e;
        e = 32'(v);
        return (e > 32'(trc_pkg::FIELD_MAX)) ? trc_pkg::FIELD_MAX : e[FW-1:0];
    endfunction

    assign in_ready = (state_reg == T_RUN);
    assign accept   = in_valid && in_ready;

    // The previous byte is settled once the current one is seen; on the final
    // byte the current one is settled as well, with nothing following it.
    always_comb begin
        ws_mid      = ws_reg;
        inside_mid  = inside_reg;
        syl_mid     = syl_reg;
        word_mid    = word_reg;
        sent_mid    = sent_reg;
        prev_counts = 1'b0;
        if (prev_valid_reg) begin
            if (!is_delim(prev_byte_reg) && inside_reg) begin
                prev_counts = is_vowel(prev_byte_reg) && !is_vowel(text_byte);
                if ((prev_byte_reg == CH_E) && (is_delim(text_byte) || is_mark(text_byte))) begin
                    prev_counts = 1'b0;
                end
                if (prev_counts) begin
                    ws_mid = sat_inc8(ws_mid);
                end
            end
            if (is_mark(prev_byte_reg) && !is_mark(text_byte)) begin
                sent_mid = sat_add(sent_mid, 8'd1);
            end
        end
        if (is_delim(text_byte)) begin
            if (inside_reg) begin
                syl_mid    = sat_add(syl_mid, word_weight(ws_mid));
                ws_mid     = 8'd0;
                inside_mid = 1'b0;
            end
        end else if (!inside_reg) begin
            inside_mid = 1'b1;
            ws_mid     = 8'd0;
            word_mid   = sat_add(word_mid, 8'd1);
        end

        ws_fin   = ws_mid;
        syl_fin  = syl_mid;
        sent_fin = sent_mid;
        if (!is_delim(text_byte) && inside_mid && is_vowel(text_byte) && (text_byte != CH_E)) begin
            ws_fin = sat_inc8(ws_fin);
        end
        if (is_mark(text_byte)) begin
            sent_fin = sat_add(sent_fin, 8'd1);
        end
        if (inside_mid) begin
            syl_fin = sat_add(syl_fin, word_weight(ws_fin));
        end
    end

    assign check_err  = (word_reg == '0) || (sent_reg == '0);
    assign calc_start = (state_reg == T_CHECK) && !check_err;

    trc_calc #(
        .COUNT_BITS (COUNT_BITS)
    ) u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .syl   (syl_reg),
        .words (word_reg),
        .sents (sent_reg),
        .res   (calc_res)
    );

    always_comb begin
        state_next      = state_reg;
        prev_byte_next  = prev_byte_reg;
        prev_valid_next = prev_valid_reg;
        inside_next     = inside_reg;
        ws_next         = ws_reg;
        syl_next        = syl_reg;
        word_next       = word_reg;
        sent_next       = sent_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg;
        syl_out_next    = syl_out_reg;
        word_out_next   = word_out_reg;
        sent_out_next   = sent_out_reg;
        index_out_next  = index_out_reg;
        err_out_next    = err_out_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            T_RUN: begin
                if (accept) begin
                    word_next = word_mid;
                    if (end_of_text) begin
                        // Counts are final; the scanner starts afresh for the next text.
                        syl_next        = syl_fin;
                        sent_next       = sent_fin;
                        prev_byte_next  = 8'd0;
                        prev_valid_next = 1'b0;
                        inside_next     = 1'b0;
                        ws_next         = 8'd0;
                        state_next      = T_CHECK;
                    end else begin
                        syl_next        = syl_mid;
                        sent_next       = sent_mid;
                        prev_byte_next  = text_byte;
                        prev_valid_next = 1'b1;
                        inside_next     = inside_mid;
                        ws_next         = ws_mid;
                    end
                end
            end
            T_CHECK: begin
                err_next   = check_err;
                state_next = check_err ? T_LOAD : T_CALC;
            end
            T_CALC: begin
                if (calc_res.done) begin
                    state_next = T_LOAD;
                end
            end
            T_LOAD: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    syl_out_next   = clamp_field(syl_reg);
                    word_out_next  = clamp_field(word_reg);
                    sent_out_next  = clamp_field(sent_reg);
                    index_out_next = err_reg ? '0 : calc_res.index;
                    err_out_next   = err_reg;
                    syl_next       = '0;
                    word_next      = '0;
                    sent_next      = '0;
                    state_next     = T_RUN;
                end
            end
            default: begin
                state_next = T_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= T_RUN;
            prev_byte_reg  <= 8'd0;
            prev_valid_reg <= 1'b0;
            inside_reg     <= 1'b0;
            ws_reg         <= 8'd0;
            syl_reg        <= '0;
            word_reg       <= '0;
            sent_reg       <= '0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev_byte_reg  <= prev_byte_next;
            prev_valid_reg <= prev_valid_next;
            inside_reg     <= inside_next;
            ws_reg         <= ws_next;
            syl_reg        <= syl_next;
            word_reg       <= word_next;
            sent_reg       <= sent_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        syl_out_reg   <= syl_out_next;
        word_out_reg  <= word_out_next;
        sent_out_reg  <= sent_out_next;
        index_out_reg <= index_out_next;
        err_out_reg   <= err_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign syllable_total = syl_out_reg;
    assign word_total     = word_out_reg;
    assign sentence_total = sent_out_reg;
    assign reading_index  = index_out_reg;
    assign index_error    = err_out_reg;

`ifndef SYNTHESIS
    a_end_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_text |=> !in_ready)
        else $error("input still taken right after the final byte");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        calc_res.done |-> state_reg == T_CALC)
        else $error("index unit finished outside of a calculation");

    a_error_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> reading_index == '0)
        else $error("index not zero on an error result");

    a_counts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !index_error |-> word_total != '0 && sentence_total != '0)
        else $error("valid index with a zero word or sentence count");

    a_index_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reading_index[IW-1] |-> reading_index <= IW'(207))
        else $error("index above its largest possible value");
`endif

endmodule

/* tb/sv/text_readability_counter_test.sv */
// Self-checking testbench for the streaming text readability counter.
`timescale 1ns / 1ps

module text_readability_counter_test;

    localparam int          COUNT_BITS   = 24;
    localparam logic [63:0] COUNT_TOP    = (64'd1 << COUNT_BITS) - 64'd1;
    // Cycles without any accepted word before the run is declared hung. The
    // longest honest quiet spell is the receiver hold-off plus one index
    // computation, so this leaves a wide margin.
    localparam int          STALL_LIMIT  = 3000;
    // Quiet cycles after the last result, longer than one index computation.
    localparam int          DRAIN_CYCLES = 60;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RANDOM_BYTES = 450;

    localparam logic [7:0] SPACE   = " ";
    localparam logic [7:0] NEWLINE = "\n";

    // One finished text as the block should report it.
    typedef struct {
        logic [trc_pkg::FIELD_W-1:0]        syllables;
        logic [trc_pkg::FIELD_W-1:0]        words;
        logic [trc_pkg::FIELD_W-1:0]        sentences;
        logic signed [trc_pkg::INDEX_W-1:0] index;
        logic                               flag;
    } tally_t;

    logic                               clk         = 1'b0;
    logic                               rst_n       = 1'b0;
    logic                               in_valid    = 1'b0;
    logic                               in_ready;
    logic [7:0]                         text_byte   = 8'h00;
    logic                               end_of_text = 1'b0;
    logic                               out_valid;
    logic                               out_ready   = 1'b0;
    logic [trc_pkg::FIELD_W-1:0]        syllable_total;
    logic [trc_pkg::FIELD_W-1:0]        word_total;
    logic [trc_pkg::FIELD_W-1:0]        sentence_total;
    logic signed [trc_pkg::INDEX_W-1:0] reading_index;
    logic                               index_error;

    // Set while neither side may idle; cleared for the rest of the run.
    logic steady      = 1'b0;
    // Set while the receiver refuses every result word.
    logic hold_output = 1'b0;

    int       errors = 0;
    tally_t   tallies[$];      // results still owed by the block, oldest first
    tally_t   want;
    logic [7:0] draft[$];      // text being assembled before it is sent

    // Shadow of the block's scanning state.
    logic [7:0]  last_char;
    logic        have_last;
    logic        in_word;
    logic [7:0]  word_syl;
    logic [63:0] syl_count;
    logic [63:0] word_count;
    logic [63:0] mark_count;

    text_readability_counter #(
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .syllable_total(syllable_total),
        .word_total    (word_total),
        .sentence_total(sentence_total),
        .reading_index (reading_index),
        .index_error   (index_error)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic bit is_vowel(input logic [7:0] b);
        return b inside {"a", "e", "i", "o", "u", "y", "A", "E", "I", "O", "U", "Y"};
    endfunction

    // Space and newline separate text words; nothing else does.
    function automatic bit is_gap(input logic [7:0] b);
        return b == SPACE || b == NEWLINE;
    endfunction

    function automatic bit is_mark(input logic [7:0] b);
        return b inside {".", "?", "!", ":", ";"};
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        return (a + b > COUNT_TOP) ? COUNT_TOP : a + b;
    endfunction

    function automatic logic [trc_pkg::FIELD_W-1:0] to_field(input logic [63:0] v);
        return (v > 64'(trc_pkg::FIELD_MAX)) ? trc_pkg::FIELD_MAX : v[trc_pkg::FIELD_W-1:0];
    endfunction

    // Flesch index 206.835 - 84.6*S/W - 1.015*W/T, scaled by 1000 so that it
    // becomes N/D with integers, then rounded half away from zero. The
    // rounding works on the magnitude: floor((2|N| + D) / 2D).
    function automatic logic signed [trc_pkg::INDEX_W-1:0] flesch_rounded(
        input logic [63:0] s, input logic [63:0] w, input logic [63:0] t);
        logic [127:0] wt, gain, loss, mag, den, q;
        logic         below;
        wt    = 128'(w) * 128'(t);
        gain  = wt * 128'd206835;
        loss  = 128'(s) * 128'(t) * 128'd84600 + 128'(w) * 128'(w) * 128'd1015;
        below = gain < loss;
        mag   = below ? loss - gain : gain - loss;
        den   = wt * 128'd1000;
        q     = (128'd2 * mag + den) / (128'd2 * den);
        if (!below)
            return q[trc_pkg::INDEX_W-1:0];
        if (q >= 128'd32768)
            return trc_pkg::INDEX_MIN;
        return -q[trc_pkg::INDEX_W-1:0];
    endfunction

    task automatic clear_tally();
        last_char  = 8'h00;
        have_last  = 1'b0;
        in_word    = 1'b0;
        word_syl   = 8'h00;
        syl_count  = 64'd0;
        word_count = 64'd0;
        mark_count = 64'd0;
    endtask

    // Judges a byte once the byte after it is known: a vowel counts unless
    // another vowel follows, and a lowercase e closing a word counts nothing.
    task automatic scan_char(input logic [7:0] b, input logic [7:0] nxt, input bit at_end);
        bit counts;
        if (!is_gap(b) && in_word)
        begin
            counts = is_vowel(b) && (at_end || !is_vowel(nxt));
            if (b == "e" && (at_end || is_gap(nxt) || is_mark(nxt)))
                counts = 1'b0;
            if (counts && word_syl != 8'hFF)
                word_syl++;
        end
        if (is_mark(b) && (at_end || !is_mark(nxt)))
            mark_count = sat_add(mark_count, 64'd1);
    endtask

    // A text word with no counted vowel still has one syllable.
    task automatic end_word();
        syl_count = sat_add(syl_count, (word_syl == 8'h00) ? 64'd1 : 64'(word_syl));
        word_syl  = 8'h00;
        in_word   = 1'b0;
    endtask

    // Advances the shadow state by one accepted byte; the final byte of a
    // text queues the result it must produce.
    task automatic track_char(input logic [7:0] c, input bit last);
        tally_t t;
        bit     bad;
        if (have_last)
            scan_char(last_char, c, 1'b0);
        if (is_gap(c))
        begin
            if (in_word)
                end_word();
        end
        else if (!in_word)
        begin
            in_word    = 1'b1;
            word_syl   = 8'h00;
            word_count = sat_add(word_count, 64'd1);
        end
        last_char = c;
        have_last = 1'b1;
        if (last)
        begin
            scan_char(c, 8'h00, 1'b1);
            if (in_word)
                end_word();
            bad         = word_count == 64'd0 || mark_count == 64'd0;
            t.syllables = to_field(syl_count);
            t.words     = to_field(word_count);
            t.sentences = to_field(mark_count);
            t.index     = bad ? '0 : flesch_rounded(syl_count, word_count, mark_count);
            t.flag      = bad;
            tallies.push_back(t);
            clear_tally();
        end
    endtask

    // ------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------

    // Offers one byte and waits until the block takes it. Valid is only
    // dropped for an idle gap, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] b, input bit last);
        while (!steady && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= last;
        do
            @(posedge clk);
        while (!in_ready);
        track_char(b, last);
    endtask

    task automatic load_string(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endtask

    // Sends the assembled text with end_of_text on its final byte.
    task automatic send_draft();
        foreach (draft[i])
            send_byte(draft[i], i == draft.size() - 1);
        draft.delete();
    endtask

    // Builds one random text in the draft. Most texts are sentences of
    // letter runs with marks and separators; the rest are short jumbles of
    // arbitrary bytes, separators and marks that often leave no word or no
    // sentence at all.
    task automatic random_text();
        int    words;
        string vowels = "aeiouyAEIOUY";
        string others = "bcdfghklmnprstwzBCDTXZ";
        string marks  = ".?!:;";
        if ($urandom_range(99) < 85)
        begin
            words = $urandom_range(8, 1);
            repeat (words)
            begin
                repeat ($urandom_range(9, 1))
                begin
                    if ($urandom_range(99) < 4)
                        draft.push_back(8'($urandom_range(255)));
                    else if ($urandom_range(1))
                        draft.push_back(vowels[$urandom_range(vowels.len() - 1)]);
                    else
                        draft.push_back(others[$urandom_range(others.len() - 1)]);
                end
                if ($urandom_range(99) < 30)
                    repeat ($urandom_range(3, 1))
                        draft.push_back(marks[$urandom_range(marks.len() - 1)]);
                draft.push_back(($urandom_range(99) < 80) ? SPACE : NEWLINE);
                if ($urandom_range(99) < 10)
                    draft.push_back(SPACE);
            end
            if ($urandom_range(1))
                void'(draft.pop_back());
        end
        else
        begin
            repeat ($urandom_range(12, 1))
            begin
                case ($urandom_range(3))
                    0:       draft.push_back(8'($urandom_range(255)));
                    1:       draft.push_back(SPACE);
                    2:       draft.push_back(NEWLINE);
                    default: draft.push_back(marks[$urandom_range(marks.len() - 1)]);
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short hand-made texts: a lone sentence mark, a text with no words, a
    // text with no sentence whose only word ends in a silent e, vowel runs in
    // both cases with a run of marks and a trailing newline, and the all-zero
    // and all-one bytes acting as plain letters before an e and a mark.
    task automatic test_directed_texts();
        load_string(".");
        send_draft();
        load_string(" ");
        send_draft();
        load_string("Be");
        send_draft();
        load_string("Eye queue!?\n");
        send_draft();
        draft.push_back(8'h00);
        draft.push_back(8'hFF);
        load_string("e;");
        send_draft();
    endtask

    // One text word of 300 syllables, so the per-word count must stop at
    // 255, followed by an ordinary word.
    task automatic test_long_word();
        repeat (300)
            load_string("ba");
        load_string(". Go.");
        send_draft();
    endtask

    // The receiver refuses results for a long spell while short texts keep
    // coming: one result sits in the output register, a second one finishes
    // behind it, and the block has to stop taking input words.
    task automatic test_output_backpressure();
        fork
            begin
                hold_output <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output <= 1'b0;
            end
        join_none
        repeat (12)
        begin
            load_string("Go on. Try it!");
            send_draft();
        end
    endtask

    // Random texts, with a stretch in the middle where neither side idles.
    task automatic test_random_texts();
        int sent;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            steady <= (sent >= 100 && sent < 350);
            random_text();
            sent += draft.size();
            send_draft();
        end
        steady <= 1'b0;
    endtask

    // Many one-letter words in a single sentence let the words-per-sentence and
    // syllable terms outweigh the base, so the index comes out below zero.
    task automatic test_long_sentence();
        repeat (150)
            load_string("a ");
        load_string("a.");
        send_draft();
    endtask

    // ------------------------------------------------------------------
    // Receiver and result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Ready is chosen at each edge for the next one; a result word is taken
    // at an edge where valid and ready are both high.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_output && (steady || $urandom_range(99) >= 8);
        if (rst_n && out_valid && out_ready)
        begin
            if (tallies.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, got %0d %0d %0d %0d %0d", $time,
                         syllable_total, word_total, sentence_total, reading_index,
                         index_error);
            end
            else
            begin
                want = tallies.pop_front();
                check_field("syllable_total", 32'(want.syllables), 32'(syllable_total));
                check_field("word_total", 32'(want.words), 32'(word_total));
                check_field("sentence_total", 32'(want.sentences), 32'(sentence_total));
                check_field("reading_index", 32'(want.index), 32'(reading_index));
                check_field("index_error", 32'(want.flag), 32'(index_error));
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel moves a word.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        clear_tally();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_texts();
        test_long_word();
        test_output_backpressure();
        test_random_texts();
        test_long_sentence();

        // Let every owed result come out, then watch for strays.
        in_valid <= 1'b0;
        while (tallies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
